[src/pcm_pkg.sv]
`timescale 1ns / 1ps

package pcm_pkg;

  // Field widths
  localparam int DIM_W          = 12;  // column and row
  localparam int PIX_W          = 8;
  localparam int HEIGHT_W       = 13;
  localparam int COEF_W         = 40;
  localparam int COEF_FRAC_BITS = 24;
  localparam int MAX_DIM        = 4096;

  // Datapath widths
  localparam int SQ_W    = 2 * DIM_W;               // x*x
  localparam int SPLIT   = COEF_W / 2;              // square coef cut into two halves
  localparam int SUM_W   = 64;                      // full fixed-point sum
  localparam int ROW_W   = SUM_W - COEF_FRAC_BITS;  // rounded curve row
  localparam int CFG_IDX_W = 3;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [PIX_W-1:0]    PIX_FULL     = '1;
  localparam logic [PIX_W-1:0]    PIX_CLEAR    = '0;

  typedef enum logic [1:0] {
    MODE_MARK        = 2'd0,
    MODE_CLEAR_BELOW = 2'd1,
    MODE_CLEAR_ABOVE = 2'd2,
    MODE_FILL        = 2'd3
  } draw_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_SQUARE  = 3'd0,
    REG_FIRST_LINEAR  = 3'd1,
    REG_FIRST_OFFSET  = 3'd2,
    REG_SECOND_SQUARE = 3'd3,
    REG_SECOND_LINEAR = 3'd4,
    REG_SECOND_OFFSET = 3'd5,
    REG_DRAW_MODE     = 3'd6,
    REG_IMAGE_HEIGHT  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] pixel_col;
    logic [DIM_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             pixel_changed;
  } out_word_t;

  // Settings the rule stage needs
  typedef struct packed {
    draw_mode_e          mode;
    logic [HEIGHT_W-1:0] height;
  } rule_cfg_t;

endpackage

[src/pcm_curve.sv]
`timescale 1ns / 1ps

// a*x^2 + b*x + c, rounded half away from zero. Four register stages.
module pcm_curve import pcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [COEF_W-1:0] square_i,
  input  logic signed [COEF_W-1:0] linear_i,
  input  logic signed [COEF_W-1:0] offset_i,
  input  logic [DIM_W-1:0]        col_i,
  input  logic [SQ_W-1:0]         col_sq_i,
  output logic signed [ROW_W-1:0] row_o
);

  localparam int LO_PROD_W  = SPLIT + 1 + SQ_W + 1;
  localparam int HI_PROD_W  = COEF_W - SPLIT + SQ_W + 1;
  localparam int LIN_PROD_W = COEF_W + DIM_W + 1;

  logic signed [SPLIT:0]          sq_lo_s;
  logic signed [COEF_W-SPLIT-1:0] sq_hi_s;
  logic signed [SQ_W:0]           col_sq_s;
  logic signed [DIM_W:0]          col_s;

  logic signed [LO_PROD_W-1:0]  prod_lo_d, prod_lo_q;
  logic signed [HI_PROD_W-1:0]  prod_hi_d, prod_hi_q;
  logic signed [LIN_PROD_W-1:0] prod_lin_d, prod_lin_q;
  logic signed [SUM_W-1:0]      sq_d, sq_q, lc_d, lc_q, sum_d, sum_q, rnd;
  logic signed [ROW_W-1:0]      row_d, row_q;

  // stage A: partial products (square coef split in halves)
  assign sq_lo_s    = $signed({1'b0, square_i[SPLIT-1:0]});
  assign sq_hi_s    = $signed(square_i[COEF_W-1:SPLIT]);
  assign col_sq_s   = $signed({1'b0, col_sq_i});
  assign col_s      = $signed({1'b0, col_i});
  assign prod_lo_d  = sq_lo_s * col_sq_s;
  assign prod_hi_d  = sq_hi_s * col_sq_s;
  assign prod_lin_d = linear_i * col_s;

  // stage B: recombine square term, linear plus offset
  assign sq_d = (SUM_W'(prod_hi_q) <<< SPLIT) + SUM_W'(prod_lo_q);
  assign lc_d = SUM_W'(prod_lin_q) + SUM_W'(offset_i);

  // stage C: full sum; range of the fields keeps it inside 64 bits
  assign sum_d = sq_q + lc_q;

  // stage D: round half away from zero
  assign rnd   = sum_q + SUM_W'(64'd1 << (COEF_FRAC_BITS - 1)) - SUM_W'(sum_q[SUM_W-1]);
  assign row_d = rnd[SUM_W-1:COEF_FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_lo_q  <= prod_lo_d;
      prod_hi_q  <= prod_hi_d;
      prod_lin_q <= prod_lin_d;
      sq_q       <= sq_d;
      lc_q       <= lc_d;
      sum_q      <= sum_d;
      row_q      <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

[src/pcm_rule.sv]
`timescale 1ns / 1ps

// Mode rule and output register.
module pcm_rule import pcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  rule_cfg_t               cfg_i,
  input  logic [DIM_W-1:0]        row_i,
  input  logic [PIX_W-1:0]        pix_i,
  input  logic signed [ROW_W-1:0] p_first_i,
  input  logic signed [ROW_W-1:0] p_second_i,
  output out_word_t               word_o
);

  logic [HEIGHT_W-1:0]   h_eff;
  logic [HEIGHT_W-1:0]   row_ext, row_inc;
  logic signed [ROW_W:0] row_s, p1_s, p2_s;
  logic                  in_image, hit;
  logic [PIX_W-1:0]      fill_val;
  out_word_t             word_d, word_q;

  assign h_eff    = (cfg_i.height > HEIGHT_W'(MAX_DIM)) ? HEIGHT_W'(MAX_DIM) : cfg_i.height;
  assign row_ext  = HEIGHT_W'(row_i);
  assign row_inc  = row_ext + HEIGHT_W'(1);
  assign in_image = row_ext < h_eff;

  assign row_s = $signed((ROW_W + 1)'(row_i));
  assign p1_s  = (ROW_W + 1)'(p_first_i);
  assign p2_s  = (ROW_W + 1)'(p_second_i);

  always_comb begin
    fill_val = PIX_CLEAR;
    hit      = 1'b0;
    unique case (cfg_i.mode)
      MODE_MARK:        hit = row_s == p1_s;
      MODE_CLEAR_BELOW: hit = row_s >= p1_s;
      // bottom row is never cleared
      MODE_CLEAR_ABOVE: hit = (row_inc < h_eff) && (row_s < p1_s);
      MODE_FILL: begin
        hit      = (row_s >= p1_s) && (row_s <= p2_s);
        fill_val = PIX_FULL;
      end
      default:          hit = 1'b0;
    endcase
    hit = hit && in_image;
    word_d.pixel_out     = hit ? fill_val : pix_i;
    word_d.pixel_changed = hit;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

[src/polynomial_curve_mask.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | in_word_i  (col, row, pixel)
// out     | output    | out_valid_o / out_ready_i| out_word_o (pixel, changed flag)
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word in and one word out per clock unless the output stalls. Registers:
// input, partial products, partial sums, full sum, rounding, rule/output. The
// throughput is set by the pipeline as a whole, every stage takes a new word
// each cycle. A stall at the output freezes all stages together; in_ready_o is
// low only while the output word is held. Reset clears the stage valid bits and
// loads the register reset values; no clearing pass.
module polynomial_curve_mask import pcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEF_W-1:0]     cfg_data_i
);

  localparam int STAGES = 5;  // stages before the output register

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [PIX_W-1:0] pix;
  } side_t;

  // config registers
  logic signed [COEF_W-1:0] coef_q [6];
  draw_mode_e               mode_q;
  logic [HEIGHT_W-1:0]      height_q;
  rule_cfg_t                rule_cfg;

  // pipeline
  logic                     en;
  logic [STAGES:1]          vld_q;
  logic                     out_valid_q;
  side_t                    side_q [1:STAGES];
  logic [DIM_W-1:0]         col1_q;
  logic [SQ_W-1:0]          col_sq1_q;
  logic signed [ROW_W-1:0]  p_first, p_second;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        coef_q[i] <= '0;
      end
      mode_q   <= MODE_MARK;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FIRST_SQUARE:  coef_q[0] <= cfg_data_i;
        REG_FIRST_LINEAR:  coef_q[1] <= cfg_data_i;
        REG_FIRST_OFFSET:  coef_q[2] <= cfg_data_i;
        REG_SECOND_SQUARE: coef_q[3] <= cfg_data_i;
        REG_SECOND_LINEAR: coef_q[4] <= cfg_data_i;
        REG_SECOND_OFFSET: coef_q[5] <= cfg_data_i;
        REG_DRAW_MODE:     mode_q    <= draw_mode_e'(cfg_data_i[1:0]);
        REG_IMAGE_HEIGHT:  height_q  <= cfg_data_i[HEIGHT_W-1:0];
        default:           mode_q    <= mode_q;
      endcase
    end
  end

  assign rule_cfg.mode   = mode_q;
  assign rule_cfg.height = height_q;

  // whole pipeline advances unless the output word is stuck
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[STAGES-1:1], in_valid_i};
      out_valid_q <= vld_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1].row <= in_word_i.pixel_row;
      side_q[1].pix <= in_word_i.pixel_in;
      col1_q        <= in_word_i.pixel_col;
      col_sq1_q     <= SQ_W'(in_word_i.pixel_col) * SQ_W'(in_word_i.pixel_col);
      for (int i = 2; i <= STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  pcm_curve u_curve_first (
    .clk_i    (clk_i),
    .en_i     (en),
    .square_i (coef_q[0]),
    .linear_i (coef_q[1]),
    .offset_i (coef_q[2]),
    .col_i    (col1_q),
    .col_sq_i (col_sq1_q),
    .row_o    (p_first)
  );

  // second curve only matters in fill mode
  pcm_curve u_curve_second (
    .clk_i    (clk_i),
    .en_i     (en),
    .square_i (coef_q[3]),
    .linear_i (coef_q[4]),
    .offset_i (coef_q[5]),
    .col_i    (col1_q),
    .col_sq_i (col_sq1_q),
    .row_o    (p_second)
  );

  pcm_rule u_rule (
    .clk_i      (clk_i),
    .en_i       (en),
    .cfg_i      (rule_cfg),
    .row_i      (side_q[STAGES].row),
    .pix_i      (side_q[STAGES].pix),
    .p_first_i  (p_first),
    .p_second_i (p_second),
    .word_o     (out_word_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

[src/pcm_checker.sv]
`timescale 1ns / 1ps

module pcm_checker import pcm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_word_i,
  input logic      cfg_ready_i
);

  // output word held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("output word dropped or changed under stall");

  // a written pixel is either cleared or filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.pixel_changed |->
      (out_word_i.pixel_out == PIX_CLEAR || out_word_i.pixel_out == PIX_FULL))
    else $error("changed pixel holds neither 0 nor 255");

  // input side never blocked while the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // input side blocked only when the output is back-pressured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without back-pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config port not ready");

endmodule

bind polynomial_curve_mask pcm_checker u_pcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o),
  .cfg_ready_i (cfg_ready_o)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for polynomial_curve_mask.
// A driver and a monitor run as clocked processes. The driver is fed from
// pixel_feed_q. Each accepted word is run through mask_pixel(), a local
// model of the curve rules, and the result goes into masked_pixels_q. The
// monitor checks every output word against the oldest entry there.
module testbench;
  import pcm_pkg::*;

  localparam int     PIPE_DEPTH   = 6;        // registers from the block's input to its output
  localparam int     HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     RAND_PHASES  = 8;
  localparam int     PHASE_WORDS  = 180;
  localparam longint COEF_MAX     = (longint'(1) <<< (COEF_W - 1)) - 1;
  localparam longint COEF_MIN     = -(longint'(1) <<< (COEF_W - 1));
  localparam longint SUM_LIMIT    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ONE_ROW      = longint'(1) <<< COEF_FRAC_BITS;

  // Clock, reset, DUT pins. Every input has a known value from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_word     = '0;
  logic                 out_valid_o;
  logic                 out_ready   = 1'b0;
  out_word_t            out_word_o;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [COEF_W-1:0]    cfg_data    = '0;

  // Local copy of the register file, updated when a config write is taken
  longint              curve_coef [6];
  draw_mode_e          cfg_mode   = MODE_MARK;
  logic [HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;

  // Stimulus and scoreboard
  in_word_t  pixel_feed_q [$];
  out_word_t masked_pixels_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go        = 1'b0;
  logic        hold_done      = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned cycle_cnt      = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned pixels_taken   = 0;
  int unsigned results_seen   = 0;
  int unsigned changed_seen   = 0;
  int unsigned reg_writes     = 0;
  int unsigned in_stall_cnt   = 0;

  polynomial_curve_mask u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the curve rules
  // ---------------------------------------------------------------------------

  // Saturating add, clamps to +-(2^63 - 1)
  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > SUM_LIMIT - b) return SUM_LIMIT;
    if (b < 0 && a < -SUM_LIMIT - b) return -SUM_LIMIT;
    return a + b;
  endfunction

  // Curve value at a column, rounded to a row, ties away from zero
  function automatic longint curve_row(bit second, logic [DIM_W-1:0] col);
    int     base;
    longint x;
    longint fx;
    longint mag;
    longint q;
    base = second ? int'(REG_SECOND_SQUARE) : int'(REG_FIRST_SQUARE);
    x    = longint'(col);
    fx   = sat_add(sat_add(curve_coef[base] * (x * x), curve_coef[base + 1] * x),
                   curve_coef[base + 2]);
    mag  = (fx < 0) ? -fx : fx;
    q    = (mag >>> COEF_FRAC_BITS) + ((mag >>> (COEF_FRAC_BITS - 1)) & 1);
    return (fx < 0) ? -q : q;
  endfunction

  // Heights past MAX_DIM behave as MAX_DIM
  function automatic int eff_height();
    return (int'(cfg_height) > MAX_DIM) ? MAX_DIM : int'(cfg_height);
  endfunction

  function automatic out_word_t mask_pixel(in_word_t w);
    longint    y;
    longint    h;
    longint    p1;
    longint    p2;
    longint    lo;
    longint    hi;
    logic      hit;
    out_word_t r;
    y   = longint'(w.pixel_row);
    h   = longint'(eff_height());
    hit = 1'b0;
    r.pixel_out = PIX_CLEAR;
    if (y < h) begin
      p1 = curve_row(1'b0, w.pixel_col);
      case (cfg_mode)
        MODE_MARK: begin
          hit = (y == p1);
        end
        MODE_CLEAR_BELOW: begin
          lo  = (p1 > 0) ? p1 : 0;
          hit = (y >= lo);
        end
        MODE_CLEAR_ABOVE: begin
          // bottom row is never cleared: the bound stops at h - 1
          hi  = (p1 < h - 1) ? p1 : h - 1;
          hit = (y < hi);
        end
        default: begin
          p2  = curve_row(1'b1, w.pixel_col);
          lo  = (p1 > 0) ? p1 : 0;
          hi  = (p2 < h - 1) ? p2 : h - 1;
          hit = (y >= lo) && (y <= hi);   // crossed curves fill nothing
          r.pixel_out = PIX_FULL;
        end
      endcase
    end
    if (!hit) r.pixel_out = w.pixel_in;
    r.pixel_changed = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: offers the next word once the current one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : pixel_driver
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        masked_pixels_q.push_back(mask_pixel(in_word));
        pixels_taken++;
      end
      if (in_valid && !in_ready_o) in_stall_cnt++;
      // valid holds with a stable word until the handshake completes
      if (!in_valid || in_ready_o) begin
        if (pixel_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word  <= pixel_feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver ready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (masked_pixels_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got pixel %0d changed %0b",
                   $time, out_word_o.pixel_out, out_word_o.pixel_changed);
          mismatch_cnt++;
        end else begin
          want = masked_pixels_q.pop_front();
          if (out_word_o.pixel_out !== want.pixel_out) begin
            $display("%0t: pixel_out expected %0d got %0d",
                     $time, want.pixel_out, out_word_o.pixel_out);
            mismatch_cnt++;
          end
          if (out_word_o.pixel_changed !== want.pixel_changed) begin
            $display("%0t: pixel_changed expected %0b got %0b",
                     $time, want.pixel_changed, out_word_o.pixel_changed);
            mismatch_cnt++;
          end
          results_seen++;
          if (out_word_o.pixel_changed === 1'b1) changed_seen++;
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end else begin
      out_ready <= 1'b0;
    end
  end

  // Long receiver hold-off, fired once; fills the pipe so in_ready_o drops
  always @(posedge clk_i) begin : hold_counter
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words still expected",
               $time, cycle_cnt, masked_pixels_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // One register write; the local copy follows on acceptance
  task automatic write_reg(reg_idx_e idx, logic [COEF_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DRAW_MODE:    cfg_mode   = draw_mode_e'(data[1:0]);
      REG_IMAGE_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
      default:          curve_coef[int'(idx)] = longint'($signed(data));
    endcase
    reg_writes++;
  endtask

  task automatic set_curve(bit second, longint a, longint b, longint c);
    if (second) begin
      write_reg(REG_SECOND_SQUARE, a[COEF_W-1:0]);
      write_reg(REG_SECOND_LINEAR, b[COEF_W-1:0]);
      write_reg(REG_SECOND_OFFSET, c[COEF_W-1:0]);
    end else begin
      write_reg(REG_FIRST_SQUARE, a[COEF_W-1:0]);
      write_reg(REG_FIRST_LINEAR, b[COEF_W-1:0]);
      write_reg(REG_FIRST_OFFSET, c[COEF_W-1:0]);
    end
  endtask

  task automatic set_rule(draw_mode_e mode, int height);
    write_reg(REG_DRAW_MODE, COEF_W'(mode));
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(height));
  endtask

  task automatic queue_pixel(int col, int row, int pix);
    in_word_t w;
    w.pixel_col = col[DIM_W-1:0];
    w.pixel_row = row[DIM_W-1:0];
    w.pixel_in  = pix[PIX_W-1:0];
    pixel_feed_q.push_back(w);
  endtask

  // Block is idle once nothing is queued, offered or expected
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_feed_q.size() != 0 || in_valid || masked_pixels_q.size() != 0);
    repeat (PIPE_DEPTH * 2) @(negedge clk_i);
  endtask

  // Random coefficient: mostly values that put the curve across the image,
  // some extremes and raw 40-bit patterns so every data bit toggles
  function automatic longint pick_coef(int term);
    logic [COEF_W-1:0] raw;
    raw = COEF_W'({$urandom, $urandom});
    case ($urandom_range(9))
      0: return 0;
      1: return COEF_MAX;
      2: return COEF_MIN;
      3: return longint'($signed(raw));
      default: begin
        if (term == 0) return longint'($urandom_range(4000)) - 2000;
        if (term == 1) return longint'($urandom_range(1 << 26)) - (1 << 25);
        return (longint'($urandom_range(4400)) - 100) * ONE_ROW
               + longint'($urandom_range(ONE_ROW - 1));
      end
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(7))
      0: return 1;
      1: return 2;
      2: return 480;
      3: return MAX_DIM;
      4: return (1 << HEIGHT_W) - 1;
      5: return $urandom_range(MAX_DIM + 1, (1 << HEIGHT_W) - 1);
      default: return $urandom_range(1, MAX_DIM);
    endcase
  endfunction

  // Most rows land near a curve or the bottom edge, where decisions flip
  task automatic feed_random(int count);
    in_word_t    w;
    longint      row;
    int unsigned pick;
    int          n;
    for (n = 0; n < count; n++) begin
      w    = $urandom;
      pick = $urandom_range(99);
      if (pick < 65)
        row = curve_row((cfg_mode == MODE_FILL) && ($urandom_range(1) == 1), w.pixel_col)
              + longint'($urandom_range(6)) - 3;
      else if (pick < 75)
        row = longint'(eff_height()) - 1 + longint'($urandom_range(1));
      else if (pick < 90)
        row = longint'($urandom_range(eff_height()));
      else
        row = longint'(w.pixel_row);
      if (row < 0) row = 0;
      if (row > MAX_DIM - 1) row = MAX_DIM - 1;
      w.pixel_row = row[DIM_W-1:0];
      pixel_feed_q.push_back(w);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int ph;
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 67, 0, 13};
    recv_pct = '{0, 0, 67, 13};
    for (int i = 0; i < 6; i++) curve_coef[i] = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: flat curve at row 0, mark mode, 480 rows
    @(negedge clk_i);
    queue_pixel(0, 0, 8'h00);        // written even though value is unchanged
    queue_pixel(4095, 0, 8'hFF);
    queue_pixel(100, 479, 8'h5A);    // last row, off the curve
    queue_pixel(100, 480, 8'h7E);    // first row outside the image
    queue_pixel(4095, 4095, 8'hFF);
    wait_idle();

    // Extreme coefficients, height past MAX_DIM
    set_curve(1'b0, COEF_MAX, COEF_MIN, COEF_MAX);
    set_rule(MODE_CLEAR_BELOW, (1 << HEIGHT_W) - 1);
    @(negedge clk_i);
    queue_pixel(0, 4095, 8'h33);
    queue_pixel(4095, 4095, 8'h44);
    queue_pixel(1, 0, 8'hC3);
    wait_idle();

    // Deep negative curve: clear-below takes every row
    set_curve(1'b0, COEF_MIN, 0, 0);
    @(negedge clk_i);
    queue_pixel(4095, 4095, 8'h11);
    queue_pixel(4095, 0, 8'h22);
    wait_idle();

    // Clear above on a one-row image: the bottom row survives
    set_curve(1'b0, 0, 0, 100 * ONE_ROW);
    set_rule(MODE_CLEAR_ABOVE, 1);
    @(negedge clk_i);
    queue_pixel(7, 0, 8'h66);
    queue_pixel(7, 1, 8'h66);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, COEF_W'(MAX_DIM));
    @(negedge clk_i);
    queue_pixel(7, 99, 8'h01);
    queue_pixel(7, 100, 8'h02);
    queue_pixel(7, 4095, 8'h03);
    wait_idle();

    // Half-row tie rounds away from zero (5.5 -> 6)
    set_curve(1'b0, 0, 0, 5 * ONE_ROW + ONE_ROW / 2);
    write_reg(REG_DRAW_MODE, COEF_W'(MODE_MARK));
    @(negedge clk_i);
    queue_pixel(0, 6, 8'h10);
    queue_pixel(0, 5, 8'h10);
    wait_idle();

    // Fill between rows 10 and 20, inclusive
    set_curve(1'b0, 0, 0, 10 * ONE_ROW);
    set_curve(1'b1, 0, 0, 20 * ONE_ROW);
    write_reg(REG_DRAW_MODE, COEF_W'(MODE_FILL));
    @(negedge clk_i);
    queue_pixel(3, 9, 8'h20);
    queue_pixel(3, 10, 8'h20);
    queue_pixel(3, 20, 8'h20);
    queue_pixel(3, 21, 8'h20);
    wait_idle();

    // Crossed curves fill nothing; zero height passes everything
    write_reg(REG_FIRST_OFFSET, COEF_W'(30 * ONE_ROW));
    @(negedge clk_i);
    queue_pixel(3, 25, 8'h40);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, '0);
    @(negedge clk_i);
    queue_pixel(3, 0, 8'h40);
    wait_idle();

    // Random phases: each mode twice, rotating idle profiles
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_curve(1'b0, pick_coef(0), pick_coef(1), pick_coef(2));
      set_curve(1'b1, pick_coef(0), pick_coef(1), pick_coef(2));
      set_rule(draw_mode_e'(ph % 4), pick_height());
      send_idle_pct  = send_pct[ph % 4];
      recv_stall_pct = recv_pct[ph % 4];
      @(negedge clk_i);
      feed_random(PHASE_WORDS);
      // first phase: sender keeps offering while the receiver holds off
      if (ph == 0) hold_go = 1'b1;
      wait_idle();
    end

    $display("covered %0d pixels in %0d checked words (%0d rewritten), %0d register writes",
             pixels_taken, results_seen, changed_seen, reg_writes);
    $display("all draw modes, heights 0..%0d, input stalled for %0d cycles",
             (1 << HEIGHT_W) - 1, in_stall_cnt);
    if (mismatch_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
